// ===== rtl/mpdq_pkg.sv =====
// mpdq_pkg: shared types and constants of the dequantizing row dot product block
// depends on nothing
package mpdq_pkg;

   localparam int OUT_ROWS  = 2048;
   localparam int ROW_BITS  = $clog2(OUT_ROWS);
   localparam int SUM_BITS  = 40;
   localparam int ACC_BITS  = 32;
   localparam int PART_BITS = 26;
   localparam int FQ_DEPTH  = 4;
   localparam int FQ_BITS   = $clog2(FQ_DEPTH);

   localparam logic [1:0] MODE_8BIT   = 2'd0;
   localparam logic [1:0] MODE_4BIT   = 2'd1;
   localparam logic [1:0] MODE_2BIT   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // one row end handed from the front to the back
   typedef struct packed {
      logic signed [SUM_BITS-1:0] dot;
      logic [15:0]                scale;
      logic [15:0]                gate;
      logic [10:0]                row;
      logic                       first;
      logic                       last;
   } row_job_type;

endpackage

// ===== rtl/mixed_precision_dequant_moe_gemv_top.sv =====
// mixed_precision_dequant_moe_gemv_top: dequantizing mixed-precision row dot product
// depends on mpdq_pkg, mpdq_front, mpdq_fifo, mpdq_back, mpdq_ram
//
//  channel   ports            transfer when
//  input     req_*, full      push && !full
//  result    rsp_*, empty     pop && !empty
//
// one byte per cycle enters the front while full is low; each row end passes the
// back through pick-up, four multiply and shift stages and a merge write with the
// store read overlapped, and an emitted row then holds the back until pop
// the job queue holds four row ends; full rises when it may overflow
// reset clears the row sum, queue and sequencer; the row store is not cleared
module mixed_precision_dequant_moe_gemv_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_weight_byte,
   input  logic [1:0]         req_bit_mode,
   input  logic signed [15:0] req_act_a,
   input  logic signed [15:0] req_act_b,
   input  logic signed [15:0] req_act_c,
   input  logic signed [15:0] req_act_d,
   input  logic [15:0]        req_row_scale,
   input  logic [15:0]        req_gate_weight,
   input  logic [10:0]        req_row_index,
   input  logic               req_row_end,
   input  logic               req_first_expert,
   input  logic               req_last_expert,
   output logic               empty,
   input  logic               pop,
   output logic [10:0]        rsp_out_row,
   output logic signed [31:0] rsp_row_value,
   output logic               rsp_saturated
);
   import mpdq_pkg::*;

   logic                take, job_valid, q_valid, job_take, res_valid;
   row_job_type         job, q_job;
   logic [FQ_BITS:0]    q_count;

   // full counts the job still in the front register and keeps one queue slot spare
   assign full = (q_count + (FQ_BITS+1)'(job_valid)) >= (FQ_BITS+1)'(FQ_DEPTH - 1);
   assign take = push && !full;

   mpdq_front u_front (
      .clock(clock), .reset(reset), .take(take),
      .weight_byte(req_weight_byte), .bit_mode(req_bit_mode),
      .act_a(req_act_a), .act_b(req_act_b), .act_c(req_act_c), .act_d(req_act_d),
      .row_scale(req_row_scale), .gate_weight(req_gate_weight),
      .row_index(req_row_index), .row_end(req_row_end),
      .first_expert(req_first_expert), .last_expert(req_last_expert),
      .job_valid(job_valid), .job(job)
   );

   mpdq_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_en(job_valid), .wr_job(job),
      .rd_en(job_take), .rd_job(q_job), .not_empty(q_valid), .count(q_count)
   );

   mpdq_back u_back (
      .clock(clock), .reset(reset), .job_valid(q_valid), .job(q_job),
      .job_take(job_take), .res_valid(res_valid), .res_row(rsp_out_row),
      .res_value(rsp_row_value), .res_sat(rsp_saturated), .res_take(pop)
   );

   assign empty = !res_valid;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_count <= (FQ_BITS+1)'(FQ_DEPTH)) else $error("job queue overflow");
   a_take_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_take |-> q_valid) else $error("back took from empty queue");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("result dropped before transfer");
endmodule

// ===== rtl/mpdq_ram.sv =====
// mpdq_ram: generic single-port-write, single-read RAM with registered read
// depends on nothing
module mpdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/mpdq_front.sv =====
// mpdq_front: unpacks codes, forms the per-byte partial sum, keeps the 40-bit row sum
// depends on mpdq_pkg
module mpdq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           weight_byte,
   input  logic [1:0]           bit_mode,
   input  logic signed [15:0]   act_a,
   input  logic signed [15:0]   act_b,
   input  logic signed [15:0]   act_c,
   input  logic signed [15:0]   act_d,
   input  logic [15:0]          row_scale,
   input  logic [15:0]          gate_weight,
   input  logic [10:0]          row_index,
   input  logic                 row_end,
   input  logic                 first_expert,
   input  logic                 last_expert,
   output logic                 job_valid,
   output mpdq_pkg::row_job_type job
);
   import mpdq_pkg::*;

   logic signed [PART_BITS-1:0] part;
   logic signed [SUM_BITS:0]    sum_wide;
   logic signed [SUM_BITS-1:0] sum_sat, dot_ff, dot_in;

   always_comb begin
      part = '0;
      case (bit_mode)
         MODE_8BIT: part = PART_BITS'($signed(weight_byte) * act_a);
         MODE_4BIT: part = PART_BITS'($signed(weight_byte[3:0]) * act_a)
                         + PART_BITS'($signed(weight_byte[7:4]) * act_b);
         MODE_2BIT: part = PART_BITS'($signed(weight_byte[1:0]) * act_a)
                         + PART_BITS'($signed(weight_byte[3:2]) * act_b)
                         + PART_BITS'($signed(weight_byte[5:4]) * act_c)
                         + PART_BITS'($signed(weight_byte[7:6]) * act_d);
         default:   part = '0;
      endcase
      sum_wide = (SUM_BITS+1)'(dot_ff) + (SUM_BITS+1)'(part);
      if (sum_wide > (SUM_BITS+1)'(SUM_MAX))      sum_sat = SUM_MAX;
      else if (sum_wide < (SUM_BITS+1)'(SUM_MIN)) sum_sat = SUM_MIN;
      else                                        sum_sat = sum_wide[SUM_BITS-1:0];
      dot_in = dot_ff;
      if (take) dot_in = row_end ? '0 : sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= '0;
         job_valid <= 1'b0;
      end else begin
         dot_ff    <= dot_in;
         job_valid <= take && row_end;
      end
      job.dot   <= sum_sat;
      job.scale <= row_scale;
      job.gate  <= gate_weight;
      job.row   <= row_index;
      job.first <= first_expert;
      job.last  <= last_expert;
   end
endmodule

// ===== rtl/mpdq_fifo.sv =====
// mpdq_fifo: short queue of row jobs between the front and the back
// depends on mpdq_pkg
module mpdq_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  mpdq_pkg::row_job_type wr_job,
   input  logic                  rd_en,
   output mpdq_pkg::row_job_type rd_job,
   output logic                  not_empty,
   output logic [mpdq_pkg::FQ_BITS:0] count
);
   import mpdq_pkg::*;

   row_job_type         slot_ff [FQ_DEPTH];
   logic [FQ_BITS-1:0]  wp_ff, rp_ff;
   logic [FQ_BITS:0]    cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (FQ_BITS+1)'(wr_en) - (FQ_BITS+1)'(rd_en);
      end
      if (wr_en) slot_ff[wp_ff] <= wr_job;
   end

   assign rd_job    = slot_ff[rp_ff];
   assign not_empty = cnt_ff != '0;
   assign count     = cnt_ff;
endmodule

// ===== rtl/mpdq_back.sv =====
// mpdq_back: scales and gates a row sum, merges it into the row store, emits rows
// depends on mpdq_pkg and mpdq_ram
module mpdq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  mpdq_pkg::row_job_type job,
   output logic                  job_take,
   output logic                  res_valid,
   output logic [10:0]           res_row,
   output logic signed [31:0]    res_value,
   output logic                  res_sat,
   input  logic                  res_take
);
   import mpdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MERGE, S_OUT
   } state_type;

   state_type                state_ff;
   row_job_type              job_ff;
   logic signed [56:0]       p_ff;       // dot * scale
   logic signed [40:0]       hi_ff;
   logic [15:0]              lo_ff;
   logic signed [57:0]       hg_ff;
   logic [31:0]              lg_ff;
   logic signed [41:0]       v_ff;
   logic signed [43:0]       acc;
   logic signed [31:0]       acc_sat;
   logic                     sat_now;
   logic [32:0]              rd_data;
   logic                     wr_en;
   logic [ROW_BITS-1:0]      slot;

   assign slot = job_ff.row[ROW_BITS-1:0];

   mpdq_ram #(.WIDTH(33), .DEPTH(OUT_ROWS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot),
      .wr_data({sat_now | (~job_ff.first & rd_data[32]), acc_sat}),
      .rd_addr(slot),
      .rd_data(rd_data)
   );

   always_comb begin
      acc = job_ff.first ? 44'(v_ff) : 44'(v_ff) + 44'($signed(rd_data[31:0]));
      sat_now = 1'b0;
      acc_sat = acc[31:0];
      if (acc > 44'sd2147483647) begin
         acc_sat = 32'h7fffffff; sat_now = 1'b1;
      end else if (acc < -44'sd2147483648) begin
         acc_sat = 32'h80000000; sat_now = 1'b1;
      end
   end

   assign wr_en    = state_ff == S_MERGE;
   assign job_take = state_ff == S_IDLE && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         res_valid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (job_valid) state_ff <= S_MUL1;
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_MUL3;
            S_MUL3: state_ff <= S_MUL4;
            S_MUL4: state_ff <= S_MERGE;
            S_MERGE: begin
               if (job_ff.last) begin
                  res_valid <= 1'b1;
                  state_ff  <= S_OUT;
               end else state_ff <= S_IDLE;
            end
            S_OUT: if (res_take) begin
               res_valid <= 1'b0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (job_take) job_ff <= job;
      p_ff  <= 57'(job_ff.dot * $signed({1'b0, job_ff.scale}));
      hi_ff <= 41'(p_ff >>> 16);
      lo_ff <= p_ff[15:0];
      hg_ff <= 58'(hi_ff * $signed({1'b0, job_ff.gate}));
      lg_ff <= lo_ff * job_ff.gate;
      v_ff  <= 42'((hg_ff + 58'(lg_ff[31:16])) >>> 16);
      if (state_ff == S_MERGE) begin
         res_row   <= job_ff.row;
         res_value <= acc_sat;
         res_sat   <= sat_now | (~job_ff.first & rd_data[32]);
      end
   end
endmodule
